// ===== hdl/pressure_to_depth_with_zero_cal_core_defines.svh =====
// Assertion macros for the pressure-to-depth core.
`ifndef PRESSURE_TO_DEPTH_WITH_ZERO_CAL_CORE_DEFINES_SVH
`define PRESSURE_TO_DEPTH_WITH_ZERO_CAL_CORE_DEFINES_SVH

// Check a same-cycle implication, sampled on clk, off during reset.
`define PTD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a next-cycle implication, sampled on clk, off during reset.
`define PTD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/ptd_pkg.sv =====
// Shared types and constants of the pressure-to-depth core.
package ptd_pkg;

	localparam int PRESSURE_BITS   = 27;
	localparam int MAX_CAL_SAMPLES = 1023;
	localparam int CNT_BITS        = 10;
	localparam int SUM_BITS        = 37;
	localparam int SCALE_BITS      = 24;
	localparam int Z_BITS          = 25;
	localparam int ALU_BITS        = 38;
	localparam int MAG_BITS        = 29;
	localparam int HI_BITS         = 30;
	localparam int CFG_IDX_BITS    = 2;
	localparam int CFG_DATA_BITS   = 27;
	localparam int STEP_BITS       = 6;
	localparam int MUL_STEPS       = SCALE_BITS;
	localparam int DIV_STEPS       = SUM_BITS;

	localparam logic [MAG_BITS-1:0] R_POS_LIMIT = 29'd16777215;
	localparam logic [MAG_BITS-1:0] R_NEG_LIMIT = 29'd16777216;
	localparam logic [Z_BITS-1:0]   Z_MAX       = 25'h0FFFFFF;
	localparam logic [Z_BITS-1:0]   Z_MIN       = 25'h1000000;

	localparam logic [PRESSURE_BITS-1:0] SURFACE_RESET = 27'd101325;
	localparam logic [SCALE_BITS-1:0]    SCALE_RESET   = 24'd1668509;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_CAL_COUNT = 2'd0,
		CFG_SURFACE   = 2'd1,
		CFG_SCALE     = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [CNT_BITS-1:0]      cal_count;
		logic [PRESSURE_BITS-1:0] surface_pa;
		logic [SCALE_BITS-1:0]    scale_q24;
	} cfg_t;

	typedef struct packed {
		logic inv;
		logic cin;
	} alu_ctl_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ACC,
		ST_CHK,
		ST_HALF,
		ST_DIV,
		ST_FIN,
		ST_DIFF1,
		ST_DIFF2,
		ST_ABS,
		ST_MUL,
		ST_RND,
		ST_OUT
	} state_t;

endpackage

// ===== hdl/ptd_cfg.sv =====
// Configuration register file of the pressure-to-depth core.
module ptd_cfg
	import ptd_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
	output cfg_t                     cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cal_count  <= '0;
			cfg_q.surface_pa <= SURFACE_RESET;
			cfg_q.scale_q24  <= SCALE_RESET;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_CAL_COUNT: cfg_q.cal_count  <= cfg_wdata[CNT_BITS-1:0];
				CFG_SURFACE:   cfg_q.surface_pa <= cfg_wdata[PRESSURE_BITS-1:0];
				CFG_SCALE:     cfg_q.scale_q24  <= cfg_wdata[SCALE_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/ptd_alu.sv =====
// Shared adder/subtractor used by every arithmetic step of the core.
module ptd_alu
	import ptd_pkg::*;
(
	input  logic [ALU_BITS-1:0] a,
	input  logic [ALU_BITS-1:0] b,
	input  alu_ctl_t            ctl,
	output logic [ALU_BITS-1:0] sum,
	output logic                cout
);

	logic [ALU_BITS-1:0] bx;

	// invert b and set carry-in for subtraction; carry-out then means no borrow
	assign bx = ctl.inv ? ~b : b;
	assign {cout, sum} = {1'b0, a} + {1'b0, bx} + {{ALU_BITS{1'b0}}, ctl.cin};

endmodule

// ===== hdl/pressure_to_depth_with_zero_cal_core.sv =====
// Depth item: request accepted, result registered in the output step once the output is free.
// Calibration item: no result; the mean is taken (37-step divide) when the count is reached.
// One 38-bit adder does all arithmetic: 24 shift-add multiply steps, 37 restoring divide steps.
// Requests are taken only in idle, after the previous item is done; a held result delays that.
// Reset (arst_n low, asynchronous): idle, no result held, offset and calibration sum cleared,
// registers back to count 0, surface 101325 Pa and scale 1668509.
module pressure_to_depth_with_zero_cal_core
	import ptd_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [PRESSURE_BITS-1:0] sample_pa,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [Z_BITS-1:0] measured_z_mm,
	output logic                     offset_calibrated
);

`include "pressure_to_depth_with_zero_cal_core_defines.svh"

	cfg_t cfg;

	state_t state_q;
	state_t state_d;

	// working registers of the shared datapath
	logic [ALU_BITS-1:0]      a_q;
	logic [SCALE_BITS-1:0]    b_q;
	logic [MAG_BITS-1:0]      m_q;
	logic [CNT_BITS-1:0]      rem_q;
	logic [STEP_BITS-1:0]     stp_q;
	logic                     neg_q;

	// calibration state
	logic [CNT_BITS-1:0]      cnt_q;
	logic [SUM_BITS-1:0]      sum_q;
	logic [PRESSURE_BITS-1:0] off_q;
	logic                     offv_q;

	// output register
	logic                     out_valid_q;
	logic [Z_BITS-1:0]        z_q;
	logic                     cal_q;

	logic [ALU_BITS-1:0]      alu_a;
	logic [ALU_BITS-1:0]      alu_b;
	alu_ctl_t                 alu_ctl;
	logic [ALU_BITS-1:0]      alu_sum;
	logic                     alu_cout;

	logic                     in_take;
	logic                     out_free;
	logic                     cal_mode;
	logic [CNT_BITS-1:0]      target;
	logic                     last_step_mul;
	logic                     last_step_div;
	logic [HI_BITS-1:0]       hi_next;
	logic                     qbit;
	logic [MAG_BITS-1:0]      r_mag;
	logic [Z_BITS-1:0]        z_next;

	ptd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	ptd_alu u_alu (
		.a    (alu_a),
		.b    (alu_b),
		.ctl  (alu_ctl),
		.sum  (alu_sum),
		.cout (alu_cout)
	);

	assign in_take  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	// average samples only while enabled and before an offset exists
	assign cal_mode = (cfg.cal_count != '0) && !offv_q;
	assign target   = (cfg.cal_count > CNT_BITS'(MAX_CAL_SAMPLES)) ?
		CNT_BITS'(MAX_CAL_SAMPLES) : cfg.cal_count;

	assign last_step_mul = (stp_q == STEP_BITS'(MUL_STEPS - 1));
	assign last_step_div = (stp_q == STEP_BITS'(DIV_STEPS - 1));

	// multiply step: add magnitude to the high half when the scale bit is set
	assign hi_next = b_q[0] ? alu_sum[HI_BITS-1:0] : a_q[HI_BITS-1:0];
	// divide step: trial subtract succeeds when no borrow
	assign qbit    = alu_cout;

	// saturate the rounded magnitude; negate for positive pressure difference
	assign r_mag = a_q[MAG_BITS-1:0];
	always_comb begin
		if (neg_q) begin
			z_next = (r_mag > R_POS_LIMIT) ? Z_MAX : r_mag[Z_BITS-1:0];
		end else begin
			z_next = (r_mag > R_NEG_LIMIT) ? Z_MIN : (~r_mag[Z_BITS-1:0] + 1'b1);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = cal_mode ? ST_ACC : ST_DIFF1;
			end
			ST_ACC:   state_d = ST_CHK;
			ST_CHK:   state_d = (cnt_q >= target) ? ST_HALF : ST_IDLE;
			ST_HALF:  state_d = ST_DIV;
			ST_DIV: begin
				if (last_step_div) state_d = ST_FIN;
			end
			ST_FIN:   state_d = ST_IDLE;
			ST_DIFF1: state_d = ST_DIFF2;
			ST_DIFF2: state_d = ST_ABS;
			ST_ABS:   state_d = ST_MUL;
			ST_MUL: begin
				if (last_step_mul) state_d = ST_RND;
			end
			ST_RND:   state_d = ST_OUT;
			ST_OUT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// operand selection for the shared adder and the input stall
	always_comb begin
		alu_a    = a_q;
		alu_b    = '0;
		alu_ctl  = '{inv: 1'b0, cin: 1'b0};
		in_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_ACC: begin
				alu_a = {1'b0, sum_q};
				alu_b = a_q;
			end
			ST_HALF: begin
				alu_a = {1'b0, sum_q};
				alu_b = {{(ALU_BITS-CNT_BITS+1){1'b0}}, cnt_q[CNT_BITS-1:1]};
			end
			ST_DIV: begin
				alu_a   = {{(ALU_BITS-CNT_BITS-1){1'b0}}, rem_q, a_q[SUM_BITS-1]};
				alu_b   = {{(ALU_BITS-CNT_BITS){1'b0}}, cnt_q};
				alu_ctl = '{inv: 1'b1, cin: 1'b1};
			end
			ST_DIFF1: begin
				alu_b   = {{(ALU_BITS-PRESSURE_BITS){1'b0}}, cfg.surface_pa};
				alu_ctl = '{inv: 1'b1, cin: 1'b1};
			end
			ST_DIFF2: begin
				alu_b   = {{(ALU_BITS-PRESSURE_BITS){1'b0}}, off_q};
				alu_ctl = '{inv: 1'b1, cin: 1'b1};
			end
			ST_ABS: begin
				alu_a   = '0;
				alu_b   = a_q;
				alu_ctl = '{inv: 1'b1, cin: 1'b1};
			end
			ST_MUL: begin
				alu_b = {{(ALU_BITS-MAG_BITS){1'b0}}, m_q};
			end
			ST_RND: begin
				alu_ctl = '{inv: 1'b0, cin: b_q[SCALE_BITS-1]};
			end
			default: ;
		endcase
	end

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			sum_q       <= '0;
			off_q       <= '0;
			offv_q      <= 1'b0;
			stp_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_ACC: begin
					sum_q <= alu_sum[SUM_BITS-1:0];
					cnt_q <= cnt_q + 1'b1;
				end
				ST_HALF: stp_q <= '0;
				ST_DIV:  stp_q <= stp_q + 1'b1;
				ST_FIN: begin
					// keep the rounded mean as the permanent offset; drop the sum
					off_q  <= a_q[PRESSURE_BITS-1:0];
					offv_q <= 1'b1;
					cnt_q  <= '0;
					sum_q  <= '0;
				end
				ST_ABS:  stp_q <= '0;
				ST_MUL:  stp_q <= stp_q + 1'b1;
				default: ;
			endcase
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_take) a_q <= {{(ALU_BITS-PRESSURE_BITS){1'b0}}, sample_pa};
			end
			ST_HALF: begin
				a_q   <= alu_sum;
				rem_q <= '0;
			end
			ST_DIV: begin
				// shift the dividend left, the quotient bit enters at the bottom
				rem_q <= qbit ? alu_sum[CNT_BITS-1:0] : {rem_q[CNT_BITS-2:0], a_q[SUM_BITS-1]};
				a_q   <= {1'b0, a_q[SUM_BITS-2:0], qbit};
			end
			ST_DIFF1, ST_DIFF2: a_q <= alu_sum;
			ST_ABS: begin
				neg_q <= a_q[ALU_BITS-1];
				m_q   <= a_q[ALU_BITS-1] ? alu_sum[MAG_BITS-1:0] : a_q[MAG_BITS-1:0];
				a_q   <= '0;
				b_q   <= cfg.scale_q24;
			end
			ST_MUL: begin
				a_q <= {{(ALU_BITS-HI_BITS+1){1'b0}}, hi_next[HI_BITS-1:1]};
				b_q <= {hi_next[0], b_q[SCALE_BITS-1:1]};
			end
			ST_RND: a_q <= alu_sum;
			ST_OUT: begin
				if (out_free) begin
					z_q   <= z_next;
					cal_q <= offv_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid         = out_valid_q;
	assign measured_z_mm     = z_q;
	assign offset_calibrated = cal_q;

	`PTD_ASSERT_NEXT(a_accept_leaves_idle, in_valid && !in_stall, state_q != ST_IDLE, "request accepted but sequencer stayed idle")
	`PTD_ASSERT_NEXT(a_result_only_from_out, !out_valid_q && state_q != ST_OUT, !out_valid_q, "result appeared outside the output step")
	`PTD_ASSERT_NEXT(a_offset_sticks, offv_q, offv_q, "calibrated offset was lost")
	`PTD_ASSERT_NEXT(a_fin_clears_count, state_q == ST_FIN, offv_q && cnt_q == '0 && sum_q == '0, "calibration finish did not clear the accumulator")

endmodule

// ===== sim/tb_pressure_to_depth_with_zero_cal_core.sv =====
// Testbench for the pressure-to-depth core: random and directed samples checked against a predictor.
module tb_pressure_to_depth_with_zero_cal_core;
	import ptd_pkg::*;

	localparam int SETTLE_CYCLES  = 50;    // long enough for a pending mean divide to finish
	localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake or register write before giving up
	localparam logic [PRESSURE_BITS-1:0] P_MAX = '1;
	localparam logic [SCALE_BITS-1:0]    S_MAX = '1;

	// One expected depth result.
	typedef struct packed {
		logic signed [Z_BITS-1:0] z_mm;
		logic                     calibrated;
	} depth_rec_t;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_we;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_wdata;
	logic                     in_valid;
	logic                     in_stall;
	logic [PRESSURE_BITS-1:0] sample_pa;
	logic                     out_valid;
	logic                     out_stall;
	logic signed [Z_BITS-1:0] measured_z_mm;
	logic                     offset_calibrated;

	// Register copies as the core should hold them.
	logic [CNT_BITS-1:0]      reg_cal_count;
	logic [PRESSURE_BITS-1:0] reg_surface_pa;
	logic [SCALE_BITS-1:0]    reg_scale_q24;

	// Calibration state as the core should hold it.
	int                       acc_count;
	longint unsigned          acc_sum;
	logic [PRESSURE_BITS-1:0] zero_pa;
	logic                     zero_ok;

	logic [PRESSURE_BITS-1:0] pending_q[$];    // samples waiting to be requested
	depth_rec_t               depth_exp_q[$];  // depth results still owed by the core
	depth_rec_t               got_rec;

	logic req_taken;
	int   idle_pct;
	int   n_queued, n_taken, n_results, n_cal_samples, n_errors;
	int   stuck_cycles;

	pressure_to_depth_with_zero_cal_core dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_wdata         (cfg_wdata),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.sample_pa         (sample_pa),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.measured_z_mm     (measured_z_mm),
		.offset_calibrated (offset_calibrated)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Depth for one sample: negate (p - surface - offset) times scale, round half away
	// from zero, clamp to the 25-bit signed range.
	function automatic logic signed [Z_BITS-1:0] depth_mm(input logic [PRESSURE_BITS-1:0] p);
		longint          diff;
		longint unsigned mag, prod, r, neg_r;
		diff = longint'({1'b0, p}) - longint'({1'b0, reg_surface_pa})
			- longint'({1'b0, zero_pa});
		mag  = (diff < 0) ? longint'(-diff) : diff;
		prod = mag * reg_scale_q24;
		r    = (prod + (64'd1 << 23)) >> 24;
		if (diff < 0) begin
			// Below the surface reading: position is positive.
			if (r > 64'd16777215)
				return Z_MAX;
			return r[Z_BITS-1:0];
		end
		if (r > 64'd16777216)
			return Z_MIN;
		neg_r = 64'd0 - r;
		return neg_r[Z_BITS-1:0];
	endfunction

	// Advance the predicted state by one accepted sample and record any depth result it owes.
	function automatic void take_sample(input logic [PRESSURE_BITS-1:0] p);
		int              target;
		longint unsigned n, mean;
		depth_rec_t      rec;
		if (reg_cal_count != 0 && !zero_ok) begin
			// Accumulate toward the zero offset; a count above the limit is clipped.
			target = (reg_cal_count > MAX_CAL_SAMPLES) ? MAX_CAL_SAMPLES : reg_cal_count;
			acc_count++;
			acc_sum += p;
			n_cal_samples++;
			if (acc_count >= target) begin
				n         = acc_count;
				mean      = (acc_sum + n / 2) / n;
				zero_pa   = mean[PRESSURE_BITS-1:0];
				zero_ok   = 1'b1;
				acc_count = 0;
				acc_sum   = 0;
			end
		end else begin
			rec.z_mm       = depth_mm(p);
			rec.calibrated = zero_ok;
			depth_exp_q.insert(depth_exp_q.size(), rec);
		end
	endfunction

	// Random sample for depth phases: full range, or clustered around the zero reading so
	// that results stay inside the output range and rounding gets exercised.
	function automatic logic [PRESSURE_BITS-1:0] pick_pressure();
		longint center, delta, v;
		int     sel;
		center = longint'({1'b0, reg_surface_pa}) + longint'({1'b0, zero_pa});
		sel    = $urandom_range(9);
		if (sel < 4)
			return PRESSURE_BITS'($urandom);
		delta = (sel < 8) ? $urandom_range(1 << 20) : $urandom_range(255);
		v     = $urandom_range(1) ? center + delta : center - delta;
		if (v < 0)
			v = 0;
		if (v > longint'({1'b0, P_MAX}))
			v = {1'b0, P_MAX};
		return v[PRESSURE_BITS-1:0];
	endfunction

	// Calibration samples: mostly near full scale to push the running sum toward its top bit.
	function automatic logic [PRESSURE_BITS-1:0] pick_cal_pressure();
		if ($urandom_range(9) < 7)
			return PRESSURE_BITS'($urandom_range(P_MAX, P_MAX - (1 << 20)));
		return PRESSURE_BITS'($urandom);
	endfunction

	task automatic queue_sample(input logic [PRESSURE_BITS-1:0] p);
		pending_q.insert(pending_q.size(), p);
		n_queued++;
	endtask

	// Write one register; only called while the core is idle, so the copy updates at once.
	task automatic set_reg(input cfg_idx_t idx, input logic [CFG_DATA_BITS-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			CFG_CAL_COUNT: reg_cal_count  = val[CNT_BITS-1:0];
			CFG_SURFACE:   reg_surface_pa = val[PRESSURE_BITS-1:0];
			CFG_SCALE:     reg_scale_q24  = val[SCALE_BITS-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait until every queued request is taken and every depth result is back, then let a
	// possible mean divide finish before anything else is written.
	task automatic drain();
		do
			@(negedge clk);
		while (n_taken != n_queued || depth_exp_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Request side and result-side stall, both driven on the falling edge.
	always @(negedge clk) begin
		if (arst_n) begin
			out_stall <= ($urandom_range(99) < idle_pct);
			// Hold a stalled request; otherwise advance to the next sample or idle.
			if (!in_valid || req_taken) begin
				if (pending_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
					in_valid  <= 1'b1;
					sample_pa <= pending_q.pop_front();
				end else begin
					in_valid  <= 1'b0;
					sample_pa <= PRESSURE_BITS'($urandom);
				end
			end
		end
	end

	// Sample both handshakes on the rising edge: predict on each taken request, check each
	// depth result against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n) begin
			req_taken <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				take_sample(sample_pa);
				n_taken++;
			end
			if (out_valid && !out_stall) begin
				n_results++;
				if (depth_exp_q.size() == 0) begin
					n_errors++;
					$error("depth result with none expected: measured_z_mm %0d", measured_z_mm);
				end else begin
					got_rec = depth_exp_q.pop_front();
					if (measured_z_mm !== got_rec.z_mm) begin
						n_errors++;
						$error("measured_z_mm: expected %0d, got %0d",
							got_rec.z_mm, measured_z_mm);
					end
					if (offset_calibrated !== got_rec.calibrated) begin
						n_errors++;
						$error("offset_calibrated: expected %0d, got %0d",
							got_rec.calibrated, offset_calibrated);
					end
				end
			end
		end
	end

	// Give up when no handshake or register write happens for too long.
	initial begin
		stuck_cycles = 0;
		while (stuck_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
				stuck_cycles = 0;
			else
				stuck_cycles++;
		end
		$display("pressure_to_depth_with_zero_cal_core test failed");
		$finish;
	end

	initial begin
		int n_first, n_second;
		// Drive every input to a known value and hold reset.
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = CFG_CAL_COUNT;
		cfg_wdata     = '0;
		in_valid      = 1'b0;
		sample_pa     = '0;
		out_stall     = 1'b0;
		req_taken     = 1'b0;
		idle_pct      = 29;
		reg_cal_count  = '0;
		reg_surface_pa = SURFACE_RESET;
		reg_scale_q24  = SCALE_RESET;
		acc_count     = 0;
		acc_sum       = 0;
		zero_pa       = '0;
		zero_ok       = 1'b0;
		n_queued      = 0;
		n_taken       = 0;
		n_results     = 0;
		n_cal_samples = 0;
		n_errors      = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset registers, no calibration: range ends and values around the surface.
		queue_sample('0);
		queue_sample(P_MAX);
		queue_sample(27'd101325);
		queue_sample(27'd101324);
		queue_sample(27'd101326);
		queue_sample(27'd101330);
		drain();

		// Full scale: hit the negative clamp exactly and one step past it.
		set_reg(CFG_SURFACE, '0);
		set_reg(CFG_SCALE, S_MAX);
		queue_sample(P_MAX);
		queue_sample('0);
		queue_sample(27'd1);
		queue_sample(27'd16777217);
		queue_sample(27'd16777218);
		drain();

		// Same scale, surface raised: the positive clamp exactly and one step past it.
		set_reg(CFG_SURFACE, 27'd67108864);
		queue_sample(27'd50331648);
		queue_sample(27'd50331647);
		queue_sample('0);
		drain();

		// Smallest scale: half a millimetre rounds away from zero on both signs.
		set_reg(CFG_SCALE, 27'd1);
		set_reg(CFG_SURFACE, '0);
		queue_sample(27'd8388608);
		queue_sample(27'd8388607);
		drain();
		set_reg(CFG_SURFACE, P_MAX);
		queue_sample(P_MAX - 27'd8388608);
		queue_sample('0);
		drain();

		// Uncalibrated depth phases over surface and scale extremes; the middle one never idles.
		for (int ph = 0; ph < 5; ph++) begin
			idle_pct = (ph == 2) ? 0 : 29;
			set_reg(CFG_CAL_COUNT, '0);
			case (ph)
				0: set_reg(CFG_SURFACE, '0);
				1: set_reg(CFG_SURFACE, P_MAX);
				2: set_reg(CFG_SURFACE, SURFACE_RESET);
				default: set_reg(CFG_SURFACE, PRESSURE_BITS'($urandom));
			endcase
			case (ph)
				0: set_reg(CFG_SCALE, S_MAX);
				1: set_reg(CFG_SCALE, 27'd1);
				2: set_reg(CFG_SCALE, SCALE_RESET);
				default: set_reg(CFG_SCALE, $urandom_range(S_MAX, 1));
			endcase
			for (int i = 0; i < 60; i++)
				queue_sample(pick_pressure());
			drain();
		end
		idle_pct = 29;

		// Calibration with the largest count, interrupted partway.
		set_reg(CFG_SURFACE, SURFACE_RESET);
		set_reg(CFG_SCALE, SCALE_RESET);
		set_reg(CFG_CAL_COUNT, 27'd1023);
		n_first = $urandom_range(350, 250);
		for (int i = 0; i < n_first; i++)
			queue_sample(pick_cal_pressure());
		drain();

		// Disable calibration midway: depth comes back with a zero offset, partial sum kept.
		set_reg(CFG_CAL_COUNT, '0);
		for (int i = 0; i < 20; i++)
			queue_sample(pick_pressure());
		drain();

		// Resume accumulating, then lower the count below what has been gathered so the
		// next sample closes the mean.
		set_reg(CFG_CAL_COUNT, 27'd1023);
		n_second = $urandom_range(250, 150);
		for (int i = 0; i < n_second; i++)
			queue_sample(pick_cal_pressure());
		drain();
		set_reg(CFG_CAL_COUNT, $urandom_range(n_first + n_second - 1, 1));
		queue_sample(pick_cal_pressure());
		drain();

		// Calibrated depth phases; count writes no longer matter once the offset is held.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: set_reg(CFG_CAL_COUNT, '0);
				1: set_reg(CFG_CAL_COUNT, 27'd1023);
				2: set_reg(CFG_CAL_COUNT, 27'd1);
				default: set_reg(CFG_CAL_COUNT, $urandom_range(1023));
			endcase
			case (ph)
				0: set_reg(CFG_SURFACE, '0);
				1: set_reg(CFG_SURFACE, P_MAX);
				default: set_reg(CFG_SURFACE, PRESSURE_BITS'($urandom));
			endcase
			case (ph)
				0: set_reg(CFG_SCALE, SCALE_RESET);
				1: set_reg(CFG_SCALE, S_MAX);
				2: set_reg(CFG_SCALE, 27'd1);
				default: set_reg(CFG_SCALE, $urandom_range(S_MAX, 1));
			endcase
			for (int i = 0; i < 60; i++)
				queue_sample(pick_pressure());
			drain();
		end

		$display("run: %0d pressure samples sent, %0d averaged into the zero offset (%0d Pa),",
			n_taken, n_cal_samples, zero_pa);
		$display("run: %0d depth results checked over clamp, rounding and register extremes",
			n_results);
		if (n_errors == 0) begin
			$display("pressure_to_depth_with_zero_cal_core test passed");
		end else begin
			$display("pressure_to_depth_with_zero_cal_core test failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/ptd_pkg.sv
hdl/ptd_cfg.sv
hdl/ptd_alu.sv
hdl/pressure_to_depth_with_zero_cal_core.sv
sim/tb_pressure_to_depth_with_zero_cal_core.sv
